FILE: hdl/path_max_projection_scatter_macros.svh
// Assertion macros for the path maximum projection scatter checks.
// Every macro samples on the rising edge of clk.
`ifndef PATH_MAX_PROJECTION_SCATTER_MACROS_SVH
`define PATH_MAX_PROJECTION_SCATTER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define PMPS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmps: check failed");

// Next-cycle implication, switched off while reset is high.
`define PMPS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmps: check failed");

// Next-cycle implication that also holds across reset.
`define PMPS_ASSERT_RST_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pmps: reset check failed");

`endif

FILE: hdl/pmps_pkg.sv
`timescale 1ns / 1ps

package pmps_pkg;

  // Voxel ids are 1-based and 17 bits wide; zero marks an empty slot.
  localparam int ID_BITS = 17;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ELEM = 2'd1,
    OP_END  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  // One classified command word as it travels through the queue.
  typedef struct packed {
    op_t               op;
    logic [ID_BITS-1:0] id;
    logic              id_ok;
  } item_t;

  localparam int ITEM_BITS = $bits(item_t);

endpackage

FILE: hdl/path_max_projection_scatter.sv
`timescale 1ns / 1ps
// An accepted word is queued, then popped into the current word register while the
// stores are read; a read result is then registered with done high. Queued words
// wait their turn: each word gets the registered read of the stores, then the
// read-modify-write of the result stores, before the back fetches the next one.
// Reset: rst clears control state; busy then stays high while the result stores
// are swept to zero. The voxel value store is not cleared.

module path_max_projection_scatter import pmps_pkg::*; #(
  parameter int VOXEL_COUNT = 65536,
  parameter int VALUE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            opcode,
  input  logic [ID_BITS-1:0]    voxel_id,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  done,
  output logic [VALUE_BITS-1:0] max_value,
  output logic [ID_BITS-1:0]    max_voxel,
  output logic [VALUE_BITS-1:0] parent_value,
  output logic [ID_BITS-1:0]    parent_voxel,
  output logic [VALUE_BITS-1:0] child_value,
  output logic [ID_BITS-1:0]    child_voxel
);

  localparam int ENTRY_W = ITEM_BITS + VALUE_BITS;

  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  logic               clearing;
  logic [ENTRY_W-1:0] entry;
  logic [ENTRY_W-1:0] q_data;

  // Front: accepts and classifies command words.
  pmps_front #(
    .VOXEL_COUNT(VOXEL_COUNT),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .start   (start),
    .opcode  (opcode),
    .voxel_id(voxel_id),
    .value   (value),
    .q_full  (q_full),
    .clearing(clearing),
    .busy    (busy),
    .push    (push),
    .entry   (entry)
  );

  // Queue between front and back.
  pmps_fifo #(
    .WIDTH(ENTRY_W)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(entry),
    .pop    (pop),
    .rd_data(q_data),
    .full   (q_full),
    .empty  (q_empty)
  );

  // Back: executes words against the stores.
  pmps_back #(
    .VOXEL_COUNT(VOXEL_COUNT),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (pop),
    .clearing    (clearing),
    .done        (done),
    .max_value   (max_value),
    .max_voxel   (max_voxel),
    .parent_value(parent_value),
    .parent_voxel(parent_voxel),
    .child_value (child_value),
    .child_voxel (child_voxel)
  );

endmodule

FILE: hdl/pmps_front.sv
`timescale 1ns / 1ps

module pmps_front import pmps_pkg::*; #(
  parameter int VOXEL_COUNT = 65536,
  parameter int VALUE_BITS  = 16
) (
  input  logic                          start,
  input  logic [1:0]                    opcode,
  input  logic [ID_BITS-1:0]            voxel_id,
  input  logic [VALUE_BITS-1:0]         value,
  input  logic                          q_full,
  input  logic                          clearing,
  output logic                          busy,
  output logic                          push,
  output logic [ITEM_BITS+VALUE_BITS-1:0] entry
);

  localparam int CMP_BITS = 32;

  item_t item;

  // Hold off new words while the queue is full or the stores are clearing.
  assign busy = q_full | clearing;
  assign push = start & ~busy;

  // Classify the word: decode the opcode and check the id range once here.
  always_comb begin
    item.op    = op_t'(opcode);
    item.id    = voxel_id;
    item.id_ok = (voxel_id != '0) &&
                 (CMP_BITS'(voxel_id) <= CMP_BITS'(VOXEL_COUNT));
  end

  assign entry = {value, item};

endmodule

FILE: hdl/pmps_fifo.sv
`timescale 1ns / 1ps

module pmps_fifo import pmps_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full    = (count == CNT_BITS'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_BITS'(1);
        2'b01:   count <= count - CNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: hdl/pmps_back.sv
`timescale 1ns / 1ps

module pmps_back import pmps_pkg::*; #(
  parameter int VOXEL_COUNT = 65536,
  parameter int VALUE_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  logic [ITEM_BITS+VALUE_BITS-1:0] q_data,
  output logic                            q_pop,
  output logic                            clearing,
  output logic                            done,
  output logic [VALUE_BITS-1:0]           max_value,
  output logic [ID_BITS-1:0]              max_voxel,
  output logic [VALUE_BITS-1:0]           parent_value,
  output logic [ID_BITS-1:0]              parent_voxel,
  output logic [VALUE_BITS-1:0]           child_value,
  output logic [ID_BITS-1:0]              child_voxel
);

  localparam int ADDR_W = (VOXEL_COUNT > 1) ? $clog2(VOXEL_COUNT) : 1;
  localparam int XW     = (ADDR_W > ID_BITS) ? ADDR_W : ID_BITS;
  localparam int REC_W  = VALUE_BITS + ID_BITS;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // Memory address of a 1-based voxel id.
  function automatic logic [ADDR_W-1:0] to_addr(input logic [ID_BITS-1:0] id);
    logic [XW-1:0] idx;
    idx = XW'(id) - XW'(1);
    return idx[ADDR_W-1:0];
  endfunction

  state_t                state;
  logic [ADDR_W-1:0]     clr_addr;

  // Word under execution.
  item_t                 cur;
  logic [VALUE_BITS-1:0] cur_value;

  // Path tracking registers.
  logic                  at_start;
  logic [VALUE_BITS-1:0] run_max;
  logic [ID_BITS-1:0]    run_org;
  logic [ADDR_W-1:0]     root_addr;
  logic                  root_ok;

  // Stores: voxel values and the three result records of max and origin.
  logic [VALUE_BITS-1:0] vox_mem  [VOXEL_COUNT];
  logic [REC_W-1:0]      comb_mem [VOXEL_COUNT];
  logic [REC_W-1:0]      par_mem  [VOXEL_COUNT];
  logic [REC_W-1:0]      chd_mem  [VOXEL_COUNT];

  logic [VALUE_BITS-1:0] vox_q;
  logic [REC_W-1:0]      comb_q;
  logic [REC_W-1:0]      par_q;
  logic [REC_W-1:0]      chd_q;

  item_t                 q_item;
  logic [VALUE_BITS-1:0] q_value;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     cur_addr;

  logic [VALUE_BITS-1:0] rm_base;
  logic [ID_BITS-1:0]    ro_base;
  logic                  elem_ok;
  logic                  rm_take;
  logic [VALUE_BITS-1:0] rm_upd;
  logic [ID_BITS-1:0]    ro_upd;
  logic                  end_go;
  logic [VALUE_BITS-1:0] comb_max;
  logic [VALUE_BITS-1:0] par_max;

  logic                  vox_we;
  logic                  comb_we;
  logic                  par_we;
  logic                  chd_we;
  logic [ADDR_W-1:0]     comb_waddr;
  logic [ADDR_W-1:0]     par_waddr;
  logic [ADDR_W-1:0]     chd_waddr;
  logic [REC_W-1:0]      comb_wdata;
  logic [REC_W-1:0]      par_wdata;
  logic [REC_W-1:0]      chd_wdata;

  assign q_item   = item_t'(q_data[ITEM_BITS-1:0]);
  assign q_value  = q_data[ITEM_BITS +: VALUE_BITS];
  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign cur_addr = to_addr(cur.id);

  // An end of path reads at the root; every other word reads at its own id.
  assign rd_addr = (q_item.op == OP_END) ? root_addr : to_addr(q_item.id);

  // Running maximum update and scatter-max decisions for the current word.
  always_comb begin
    rm_base  = at_start ? '0 : run_max;
    ro_base  = at_start ? '0 : run_org;
    elem_ok  = (cur.op == OP_ELEM) && cur.id_ok;
    rm_take  = elem_ok && (vox_q > rm_base);
    rm_upd   = rm_take ? vox_q : rm_base;
    ro_upd   = rm_take ? cur.id : ro_base;
    end_go   = (cur.op == OP_END) && !at_start && root_ok;
    comb_max = comb_q[REC_W-1 -: VALUE_BITS];
    par_max  = par_q[REC_W-1 -: VALUE_BITS];
  end

  // Write ports: the clearing sweep, then the writes of the executing word.
  always_comb begin
    vox_we     = (state == S_EXEC) && (cur.op == OP_LOAD) && cur.id_ok;
    comb_we    = 1'b0;
    par_we     = 1'b0;
    chd_we     = 1'b0;
    comb_waddr = cur_addr;
    par_waddr  = cur_addr;
    chd_waddr  = root_addr;
    comb_wdata = {rm_upd, ro_upd};
    par_wdata  = {rm_upd, ro_upd};
    chd_wdata  = {run_max, run_org};
    if (state == S_CLEAR) begin
      comb_we    = 1'b1;
      par_we     = 1'b1;
      chd_we     = 1'b1;
      comb_waddr = clr_addr;
      par_waddr  = clr_addr;
      chd_waddr  = clr_addr;
      comb_wdata = '0;
      par_wdata  = '0;
      chd_wdata  = '0;
    end else if (state == S_EXEC) begin
      if (elem_ok) begin
        par_we  = (rm_upd > par_max);
        comb_we = (rm_upd > comb_max);
      end else if (end_go) begin
        chd_we     = 1'b1;
        comb_we    = (run_max > comb_max);
        comb_waddr = root_addr;
        comb_wdata = {run_max, run_org};
      end
    end
  end

  // Voxel value store.
  always_ff @(posedge clk) begin
    if (vox_we) begin
      vox_mem[cur_addr] <= cur_value;
    end
    if (q_pop) begin
      vox_q <= vox_mem[rd_addr];
    end
  end

  // Combined result store.
  always_ff @(posedge clk) begin
    if (comb_we) begin
      comb_mem[comb_waddr] <= comb_wdata;
    end
    if (q_pop) begin
      comb_q <= comb_mem[rd_addr];
    end
  end

  // Parent result store.
  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    if (q_pop) begin
      par_q <= par_mem[rd_addr];
    end
  end

  // Child result store.
  always_ff @(posedge clk) begin
    if (chd_we) begin
      chd_mem[chd_waddr] <= chd_wdata;
    end
    if (q_pop) begin
      chd_q <= chd_mem[rd_addr];
    end
  end

  // Sequencer: clearing sweep, then fetch and execute one word at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      at_start <= 1'b1;
      run_max  <= '0;
      run_org  <= '0;
      root_ok  <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(VOXEL_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cur       <= q_item;
            cur_value <= q_value;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          unique case (cur.op)
            OP_ELEM: begin
              if (at_start) begin
                root_addr <= cur_addr;
                root_ok   <= cur.id_ok;
                at_start  <= 1'b0;
              end
              run_max <= rm_upd;
              run_org <= ro_upd;
            end
            OP_END: begin
              at_start <= 1'b1;
              run_max  <= '0;
              run_org  <= '0;
              root_ok  <= 1'b0;
            end
            OP_READ: begin
              done <= 1'b1;
              if (cur.id_ok) begin
                max_value    <= comb_q[REC_W-1 -: VALUE_BITS];
                max_voxel    <= comb_q[ID_BITS-1:0];
                parent_value <= par_q[REC_W-1 -: VALUE_BITS];
                parent_voxel <= par_q[ID_BITS-1:0];
                child_value  <= chd_q[REC_W-1 -: VALUE_BITS];
                child_voxel  <= chd_q[ID_BITS-1:0];
              end else begin
                max_value    <= '0;
                max_voxel    <= '0;
                parent_value <= '0;
                parent_voxel <= '0;
                child_value  <= '0;
                child_voxel  <= '0;
              end
            end
            default: begin
              // A load only writes the voxel store.
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/pmps_checker.sv
`timescale 1ns / 1ps
`include "path_max_projection_scatter_macros.svh"

module pmps_checker import pmps_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] opcode,
  input logic       done
);

  logic [2:0] pending;
  logic       rd_acc;

  assign rd_acc = start && !busy && (opcode == OP_READ);

  // Count read words accepted whose result has not come out yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({rd_acc, done})
        2'b10:   pending <= pending + 3'd1;
        2'b01:   pending <= pending - 3'd1;
        default: pending <= pending;
      endcase
    end
  end

  // The stores are swept after reset, so the block reports busy at once.
  `PMPS_ASSERT_RST_NXT(a_busy_after_rst, rst, busy)
  // No result comes out in the cycle after reset.
  `PMPS_ASSERT_RST_NXT(a_quiet_after_rst, rst, !done)
  // Every result answers an accepted read word.
  `PMPS_ASSERT_IMP(a_done_has_read, done, pending != 3'd0)
  // Execute always returns to idle, so results never come back to back.
  `PMPS_ASSERT_NXT(a_done_spaced, done, !done)

endmodule

bind path_max_projection_scatter pmps_checker u_pmps_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .opcode(opcode),
  .done  (done)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pmps_pkg::*;

  localparam int VOXELS = 65536;
  localparam int RANDOM_WORDS = 600;
  localparam int POOL_SIZE = 24;
  localparam int CALM_AFTER = 520;

  // One read word as returned by the block.
  typedef struct packed {
    logic [15:0] max_v;
    logic [16:0] max_id;
    logic [15:0] parent_v;
    logic [16:0] parent_id;
    logic [15:0] child_v;
    logic [16:0] child_id;
  } readout_t;

  // One row of the directed table.
  typedef struct packed {
    op_t         op;
    logic [16:0] id;
    logic [15:0] val;
    logic        typed;
    readout_t    want;
  } step_t;

  localparam readout_t ALL_ZERO = '0;
  localparam int DIRECTED_ROWS = 28;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  opcode = 2'd0;
  logic [16:0] voxel_id = 17'd0;
  logic [15:0] value = 16'd0;
  logic        busy;
  logic        done;
  logic [15:0] max_value;
  logic [16:0] max_voxel;
  logic [15:0] parent_value;
  logic [16:0] parent_voxel;
  logic [15:0] child_value;
  logic [16:0] child_voxel;

  // Predicted contents of the block's stores, indexed by 1-based voxel id.
  bit [15:0] vox_val [1:VOXELS];
  bit [15:0] comb_peak [1:VOXELS];
  bit [16:0] comb_from [1:VOXELS];
  bit [15:0] parent_peak [1:VOXELS];
  bit [16:0] parent_from [1:VOXELS];
  bit [15:0] child_peak [1:VOXELS];
  bit [16:0] child_from [1:VOXELS];
  bit [15:0] path_peak = '0;
  bit [16:0] path_peak_id = '0;
  bit [16:0] path_root = '0;
  bit        awaiting_root = 1'b1;

  readout_t    readouts_due [$];
  int          failures = 0;
  int          words_sent = 0;
  bit          typed_on = 1'b0;
  readout_t    typed_want = '0;
  logic [16:0] pool [POOL_SIZE];

  // Directed table: typed results only where they are plain zero.
  step_t plan [DIRECTED_ROWS] = '{
    '{OP_READ, 17'd1,      16'd0,     1'b1, ALL_ZERO},
    '{OP_READ, 17'd65536,  16'd0,     1'b1, ALL_ZERO},
    '{OP_READ, 17'd0,      16'd0,     1'b1, ALL_ZERO},
    '{OP_READ, 17'd131071, 16'd0,     1'b1, ALL_ZERO},
    '{OP_LOAD, 17'd1,      16'd65535, 1'b0, ALL_ZERO},
    '{OP_LOAD, 17'd65536,  16'd0,     1'b0, ALL_ZERO},
    '{OP_LOAD, 17'd2,      16'd100,   1'b0, ALL_ZERO},
    '{OP_LOAD, 17'd3,      16'd100,   1'b0, ALL_ZERO},
    '{OP_LOAD, 17'd0,      16'd555,   1'b0, ALL_ZERO},
    '{OP_LOAD, 17'd131071, 16'd65535, 1'b0, ALL_ZERO},
    '{OP_ELEM, 17'd2,      16'd0,     1'b0, ALL_ZERO},
    '{OP_ELEM, 17'd1,      16'd0,     1'b0, ALL_ZERO},
    '{OP_ELEM, 17'd0,      16'd0,     1'b0, ALL_ZERO},
    '{OP_ELEM, 17'd65536,  16'd0,     1'b0, ALL_ZERO},
    '{OP_END,  17'd0,      16'd0,     1'b0, ALL_ZERO},
    '{OP_READ, 17'd2,      16'd0,     1'b0, ALL_ZERO},
    '{OP_READ, 17'd65536,  16'd0,     1'b0, ALL_ZERO},
    '{OP_END,  17'd0,      16'd0,     1'b0, ALL_ZERO},
    '{OP_ELEM, 17'd0,      16'd0,     1'b0, ALL_ZERO},
    '{OP_ELEM, 17'd3,      16'd0,     1'b0, ALL_ZERO},
    '{OP_END,  17'd0,      16'd0,     1'b0, ALL_ZERO},
    '{OP_ELEM, 17'd3,      16'd0,     1'b0, ALL_ZERO},
    '{OP_ELEM, 17'd2,      16'd0,     1'b0, ALL_ZERO},
    '{OP_END,  17'd0,      16'd0,     1'b0, ALL_ZERO},
    '{OP_ELEM, 17'd65536,  16'd0,     1'b0, ALL_ZERO},
    '{OP_END,  17'd0,      16'd0,     1'b0, ALL_ZERO},
    '{OP_READ, 17'd3,      16'd0,     1'b0, ALL_ZERO},
    '{OP_READ, 17'd65536,  16'd0,     1'b0, ALL_ZERO}
  };

  path_max_projection_scatter u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .voxel_id     (voxel_id),
    .value        (value),
    .done         (done),
    .max_value    (max_value),
    .max_voxel    (max_voxel),
    .parent_value (parent_value),
    .parent_voxel (parent_voxel),
    .child_value  (child_value),
    .child_voxel  (child_voxel)
  );

  always #5 clk = ~clk;

  // Applies one accepted word to the predicted stores; a read yields its readout.
  task automatic project_word(input op_t op, input logic [16:0] id,
                              input logic [15:0] val, output readout_t r);
    bit hit;
    hit = (id >= 1) && (id <= VOXELS);
    r = '0;
    case (op)
      OP_LOAD: begin
        if (hit) vox_val[id] = val;
      end
      OP_ELEM: begin
        // The first element of a path names its root, even when the slot is empty.
        if (awaiting_root) begin
          path_root = id;
          path_peak = '0;
          path_peak_id = '0;
          awaiting_root = 1'b0;
        end
        if (hit) begin
          if (vox_val[id] > path_peak) begin
            path_peak = vox_val[id];
            path_peak_id = id;
          end
          if (path_peak > parent_peak[id]) begin
            parent_peak[id] = path_peak;
            parent_from[id] = path_peak_id;
          end
          if (path_peak > comb_peak[id]) begin
            comb_peak[id] = path_peak;
            comb_from[id] = path_peak_id;
          end
        end
      end
      OP_END: begin
        // The child record at the root is overwritten; the combined one only grows.
        if (!awaiting_root && path_root >= 1 && path_root <= VOXELS) begin
          child_peak[path_root] = path_peak;
          child_from[path_root] = path_peak_id;
          if (path_peak > comb_peak[path_root]) begin
            comb_peak[path_root] = path_peak;
            comb_from[path_root] = path_peak_id;
          end
        end
        awaiting_root = 1'b1;
        path_peak = '0;
        path_peak_id = '0;
        path_root = '0;
      end
      OP_READ: begin
        if (hit) begin
          r = '{comb_peak[id], comb_from[id], parent_peak[id], parent_from[id],
                child_peak[id], child_from[id]};
        end
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [16:0] want,
                             input logic [16:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      failures++;
    end
  endtask

  // Checks each result word and predicts each accepted command word.
  always @(posedge clk) begin : watch
    readout_t got;
    readout_t want;
    readout_t predicted;
    if (!rst) begin
      if (done === 1'b1) begin
        got = '{max_value, max_voxel, parent_value, parent_voxel,
                child_value, child_voxel};
        if (readouts_due.size() == 0) begin
          $display("%0t: result word with none expected, got %h", $time, got);
          failures++;
        end else begin
          want = readouts_due.pop_front();
          check_field("max_value", 17'(want.max_v), 17'(got.max_v));
          check_field("max_voxel", want.max_id, got.max_id);
          check_field("parent_value", 17'(want.parent_v), 17'(got.parent_v));
          check_field("parent_voxel", want.parent_id, got.parent_id);
          check_field("child_value", 17'(want.child_v), 17'(got.child_v));
          check_field("child_voxel", want.child_id, got.child_id);
        end
      end
      if (start && !busy) begin
        project_word(op_t'(opcode), voxel_id, value, predicted);
        if (op_t'(opcode) == OP_READ) readouts_due.push_back(typed_on ? typed_want : predicted);
      end
    end
  end

  // Holds start low with junk on the data lines; n sets how long.
  task automatic rest(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      opcode <= 2'($urandom);
      voxel_id <= 17'($urandom);
      value <= 16'($urandom);
    end
  endtask

  task automatic send_word(input op_t op, input logic [16:0] id, input logic [15:0] val,
                           input bit typed = 1'b0, input readout_t want = '0);
    @(negedge clk);
    start <= 1'b1;
    opcode <= op;
    voxel_id <= id;
    value <= val;
    typed_on = typed;
    typed_want = want;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  // Random gaps from the sender, none near the end of the run.
  task automatic pace();
    if (words_sent < CALM_AFTER && $urandom_range(0, 4) == 0) rest($urandom_range(1, 7));
  endtask

  task automatic drain();
    rest(1);
    while (readouts_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [16:0] empty_slot();
    return ($urandom_range(0, 1) == 0) ? 17'd0 : 17'($urandom_range(VOXELS + 1, 131071));
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int len;
    int kind;
    int first_random;
    bit drained_mid;
    drained_mid = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (plan[i]) begin
      send_word(plan[i].op, plan[i].id, plan[i].val, plan[i].typed, plan[i].want);
    end
    drain();

    // Load a pool of voxels that paths may visit: the id extremes and a dense low block.
    foreach (pool[i]) begin
      case (i)
        0: pool[i] = 17'd1;
        1: pool[i] = 17'd65536;
        2: pool[i] = 17'd65535;
        default: pool[i] = (i < 14) ? 17'(i) : 17'($urandom_range(1, VOXELS));
      endcase
      pace();
      send_word(OP_LOAD, pool[i], pick_value());
    end

    first_random = words_sent;
    while (words_sent - first_random < RANDOM_WORDS) begin
      if (!drained_mid && words_sent - first_random > RANDOM_WORDS / 2) begin
        drain();
        drained_mid = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // Well-formed path with an occasional empty slot.
        len = $urandom_range(1, 6);
        repeat (len) begin
          pace();
          if ($urandom_range(0, 11) == 0) send_word(OP_ELEM, empty_slot(), 16'($urandom));
          else send_word(OP_ELEM, pool[$urandom_range(0, POOL_SIZE - 1)], 16'($urandom));
        end
        pace();
        send_word(OP_END, 17'($urandom), 16'($urandom));
      end else if (kind < 78) begin
        pace();
        if ($urandom_range(0, 4) == 0) send_word(OP_READ, 17'($urandom), 16'($urandom));
        else send_word(OP_READ, pool[$urandom_range(0, POOL_SIZE - 1)], 16'($urandom));
      end else if (kind < 86) begin
        pace();
        send_word(OP_LOAD, pool[$urandom_range(0, POOL_SIZE - 1)], pick_value());
      end else if (kind < 92) begin
        // Noise: ignored loads, ends with no path, paths rooted on an empty slot.
        pace();
        case ($urandom_range(0, 2))
          0: send_word(OP_LOAD, empty_slot(), 16'($urandom));
          1: send_word(OP_END, 17'($urandom), 16'($urandom));
          default: send_word(OP_ELEM, empty_slot(), 16'($urandom));
        endcase
      end else begin
        // Broken path: elements whose end comes with a later path.
        len = $urandom_range(1, 3);
        repeat (len) begin
          pace();
          send_word(OP_ELEM, pool[$urandom_range(0, POOL_SIZE - 1)], 16'($urandom));
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Covers the clearing sweep after reset and the whole run several times over.
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
